// File: src/hex_to_base64_encoder_core_defines.svh
// assertion macros shared by the encoder modules
`ifndef HEX_TO_BASE64_ENCODER_CORE_DEFINES_SVH
`define HEX_TO_BASE64_ENCODER_CORE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define H2B_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define H2B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/h2b_pkg.sv
// shared types, constants and character maps of the hex to base64 encoder
package h2b_pkg;

  // results one input beat can cause at most
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountW = $clog2(MaxResults + 1);
  localparam int unsigned IdxW = $clog2(MaxResults);

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // ascii codes used by the maps
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiNine  = 8'h39;
  localparam logic [7:0] AsciiUpA   = 8'h41;
  localparam logic [7:0] AsciiUpF   = 8'h46;
  localparam logic [7:0] AsciiLowA  = 8'h61;
  localparam logic [7:0] AsciiLowF  = 8'h66;
  localparam logic [7:0] AsciiPlus  = 8'h2b;
  localparam logic [7:0] AsciiSlash = 8'h2f;
  localparam logic [7:0] AsciiPad   = 8'h3d;

  // input beat
  typedef struct packed {
    logic [7:0] hex_char;
    logic       end_of_stream;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       bad_input;
    logic       last_out;
  } out_beat_t;

  // all results of one input beat, in order
  typedef struct packed {
    out_beat_t [MaxResults-1:0] items;
    logic [CountW-1:0]          count;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // 6-bit group to base64 character
  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return AsciiUpA + w;
    if (v < 6'd52) return AsciiLowA + w - 8'd26;
    if (v < 6'd62) return AsciiZero + w - 8'd52;
    if (v == 6'd62) return AsciiPlus;
    return AsciiSlash;
  endfunction

  // hex digit to {invalid, nibble}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= AsciiZero && c <= AsciiNine) begin
      d = c - AsciiZero;
      return {1'b0, d[3:0]};
    end
    if (c >= AsciiLowA && c <= AsciiLowF) begin
      d = c - AsciiLowA + 8'd10;
      return {1'b0, d[3:0]};
    end
    if (c >= AsciiUpA && c <= AsciiUpF) begin
      d = c - AsciiUpA + 8'd10;
      return {1'b0, d[3:0]};
    end
    return 5'b10000;
  endfunction

endpackage

// File: src/h2b_front.sv
// front part: accepts hex beats, merges nibbles and builds the result job
module h2b_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  h2b_pkg::in_beat_t  in_beat_i,
  input  h2b_pkg::q_stat_t   q_stat_i,
  output logic               push_o,
  output h2b_pkg::job_t      job_o
);
  import h2b_pkg::*;

  logic       nw_q, nw_d;
  logic [3:0] hn_q, hn_d;
  logic [1:0] ph_q, ph_d;
  logic [3:0] lo_q, lo_d;

  logic              accept;
  logic [4:0]        hv;
  logic [7:0]        byte_val;
  logic              bad;
  logic [CountW-1:0] n;
  logic [IdxW-1:0]   last_idx;
  job_t              job;

  function automatic out_beat_t mk_beat(logic [7:0] ch, logic has, logic flag);
    out_beat_t b;
    b.out_char  = ch;
    b.has_char  = has;
    b.bad_input = flag;
    b.last_out  = 1'b0;
    return b;
  endfunction

  assign accept = in_valid_i && !q_stat_i.full;
  assign in_stall_o = q_stat_i.full;

  // state update and result list for one beat
  always_comb begin
    nw_d = nw_q;
    hn_d = hn_q;
    ph_d = ph_q;
    lo_d = lo_q;
    hv = hex_value(in_beat_i.hex_char);
    byte_val = {hn_q, hv[3:0]};
    bad = hv[4];
    n = '0;
    job = '0;
    last_idx = '0;

    if (!hv[4]) begin
      if (!nw_q) begin
        hn_d = hv[3:0];
        nw_d = 1'b1;
      end else begin
        nw_d = 1'b0;
        hn_d = 4'h0;
        case (ph_q)
          2'd1: begin
            job.items[0] = mk_beat(b64_char({lo_q[1:0], byte_val[7:4]}), 1'b1, 1'b0);
            n = CountW'(1);
            lo_d = byte_val[3:0];
            ph_d = 2'd2;
          end
          2'd2: begin
            job.items[0] = mk_beat(b64_char({lo_q, byte_val[7:6]}), 1'b1, 1'b0);
            job.items[1] = mk_beat(b64_char(byte_val[5:0]), 1'b1, 1'b0);
            n = CountW'(2);
            lo_d = 4'h0;
            ph_d = 2'd0;
          end
          default: begin
            job.items[0] = mk_beat(b64_char(byte_val[7:2]), 1'b1, 1'b0);
            n = CountW'(1);
            lo_d = {2'b00, byte_val[1:0]};
            ph_d = 2'd1;
          end
        endcase
      end
    end

    // odd final nibble
    if (in_beat_i.end_of_stream && nw_d) bad = 1'b1;

    // flagged result first
    if (bad) begin
      job.items[n[IdxW-1:0]] = mk_beat(8'h00, 1'b0, 1'b1);
      n = n + CountW'(1);
    end

    // flush and padding at end of stream
    if (in_beat_i.end_of_stream) begin
      case (ph_d)
        2'd1: begin
          job.items[n[IdxW-1:0]] = mk_beat(b64_char({lo_d[1:0], 4'h0}), 1'b1, 1'b0);
          n = n + CountW'(1);
          job.items[n[IdxW-1:0]] = mk_beat(AsciiPad, 1'b1, 1'b0);
          n = n + CountW'(1);
          job.items[n[IdxW-1:0]] = mk_beat(AsciiPad, 1'b1, 1'b0);
          n = n + CountW'(1);
        end
        2'd2: begin
          job.items[n[IdxW-1:0]] = mk_beat(b64_char({lo_d, 2'b00}), 1'b1, 1'b0);
          n = n + CountW'(1);
          job.items[n[IdxW-1:0]] = mk_beat(AsciiPad, 1'b1, 1'b0);
          n = n + CountW'(1);
        end
        default: ;
      endcase
      // end marker when nothing else goes out
      if (n == '0) begin
        job.items[0] = mk_beat(8'h00, 1'b0, 1'b0);
        n = CountW'(1);
      end
      last_idx = IdxW'(n - CountW'(1));
      job.items[last_idx].last_out = 1'b1;
      nw_d = 1'b0;
      hn_d = 4'h0;
      ph_d = 2'd0;
      lo_d = 4'h0;
    end
    job.count = n;
  end

  assign push_o = accept && (n != '0);
  assign job_o = job;

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nw_q <= 1'b0;
      hn_q <= 4'h0;
      ph_q <= 2'd0;
      lo_q <= 4'h0;
    end else if (accept) begin
      nw_q <= nw_d;
      hn_q <= hn_d;
      ph_q <= ph_d;
      lo_q <= lo_d;
    end
  end

endmodule

// File: src/h2b_fifo.sv
// short queue of result jobs between front and back
module h2b_fifo #(
  parameter int unsigned Depth = h2b_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  h2b_pkg::job_t     push_job_i,
  input  logic              pop_i,
  output h2b_pkg::job_t     head_o,
  output h2b_pkg::q_stat_t  stat_o
);
  import h2b_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d = push_i ? wrap_inc(wr_q) : wr_q;
    rd_d = pop_i ? wrap_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_job_i;
  end

`include "hex_to_base64_encoder_core_defines.svh"

  `H2B_ASSERT(a_no_overflow, !(push_i && stat_o.full), "push into full queue")
  `H2B_ASSERT(a_no_underflow, !(pop_i && stat_o.empty), "pop from empty queue")
  `H2B_ASSERT_NEXT(a_count_up, push_i && !pop_i, cnt_q == $past(cnt_q) + CW'(1), "count lost")

endmodule

// File: src/h2b_back.sv
// back part: plays jobs out one result beat at a time through an output register
module h2b_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  h2b_pkg::job_t       head_i,
  input  h2b_pkg::q_stat_t    q_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output h2b_pkg::out_beat_t  out_beat_o
);
  import h2b_pkg::*;

  job_t            cur_q;
  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  out_beat_t       out_q;
  logic            advance;
  logic            cur_done;

  assign advance  = !out_valid_q || !out_stall_i;
  assign pop_o    = advance && !busy_q && !q_stat_i.empty;
  assign cur_done = ({1'b0, idx_q} + CountW'(1)) == cur_q.count;

  // control of the play-out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      if (busy_q) begin
        out_valid_q <= 1'b1;
        idx_q <= idx_q + IdxW'(1);
        if (cur_done) busy_q <= 1'b0;
      end else if (!q_stat_i.empty) begin
        out_valid_q <= 1'b1;
        idx_q <= IdxW'(1);
        busy_q <= (head_i.count > CountW'(1));
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // current job and output beat
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (busy_q) begin
        out_q <= cur_q.items[idx_q];
      end else if (!q_stat_i.empty) begin
        out_q <= head_i.items[0];
        cur_q <= head_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`include "hex_to_base64_encoder_core_defines.svh"

  `H2B_ASSERT(a_idx_in_job, !busy_q || (({1'b0, idx_q}) < cur_q.count), "index past job end")
  `H2B_ASSERT(a_empty_char, !out_valid_q || out_q.has_char || (out_q.out_char == 8'h00),
    "char set on an empty result")
  `H2B_ASSERT(a_pop_idle, !(pop_o && busy_q), "pop while a job is still playing")

endmodule

// File: src/hex_to_base64_encoder_core.sv
// top level of the hex to base64 stream encoder
//
//  channel | handshake                | beat
//  --------+--------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o  | in_beat_i  (hex_char, end_of_stream)
//  out     | out_valid_o / out_stall_i| out_beat_o (out_char, has_char,
//          |                          |             bad_input, last_out)
//
// one input beat is taken per cycle while the job queue has room; the front
// builds all of its results (0 to 4) in that cycle
// the back sends one result beat per cycle from its output register while
// out_stall_i is low, so a job holds the back until all of its results are
// sent; the first result passes through the job queue and the output register
// reset clears the stream state, the queue and the output valid at once
// out stall backs up the queue (QueueDepth jobs); in_stall_o rises when full
module hex_to_base64_encoder_core #(
  parameter int unsigned QueueDepth = h2b_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  h2b_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output h2b_pkg::out_beat_t  out_beat_o
);
  import h2b_pkg::*;

  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;

  // classify input and build jobs
  h2b_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  // job queue
  h2b_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  // play results out
  h2b_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// File: tb/tb_hex_to_base64_encoder_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the hex to base64 stream encoder core
module tb_hex_to_base64_encoder_core;
  import h2b_pkg::*;

  localparam int ClkHalf = 5;
  localparam int ResetCycles = 6;
  localparam int IdlePct = 17;
  localparam int HoldCycles = 80;
  localparam int TailCycles = 20;
  localparam int QuietLimit = 3000;

  // position of the next byte inside its 3-byte group
  typedef enum logic [1:0] {
    GrpFirst,
    GrpSecond,
    GrpThird
  } grp_pos_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  // pending hex characters and predicted base64 beats
  in_beat_t  hex_fifo[$];
  out_beat_t b64_expect[$];

  // encoder state as predicted
  bit        nib_held = 1'b0;
  logic [3:0] hi_nib = 4'h0;
  grp_pos_e  grp_pos = GrpFirst;
  logic [3:0] carry_bits = 4'h0;

  int  errors = 0;
  int  idle_pct = IdlePct;
  int  items_queued = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  bit  in_taken = 1'b0;

  hex_to_base64_encoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #ClkHalf;
    clk_i = 1'b1;
    #ClkHalf;
  end

  // 6-bit group to its base64 character
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
    if (s == 6'd63) return AsciiSlash;
    if (s == 6'd62) return AsciiPlus;
    if (s >= 6'd52) return AsciiZero + {2'b00, s - 6'd52};
    if (s >= 6'd26) return AsciiLowA + {2'b00, s - 6'd26};
    return AsciiUpA + {2'b00, s};
  endfunction

  // hex digit to nibble, returns 0 for anything else
  function automatic bit decode_hex(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'h0;
    if (c >= AsciiZero && c <= AsciiNine) begin
      nib = c[3:0];
      return 1'b1;
    end
    // 'a'..'f' and 'A'..'F' both have low nibble 1..6
    if ((c >= AsciiLowA && c <= AsciiLowF) || (c >= AsciiUpA && c <= AsciiUpF)) begin
      nib = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_beat_t char_beat(input logic [7:0] ch);
    return '{out_char: ch, has_char: 1'b1, bad_input: 1'b0, last_out: 1'b0};
  endfunction

  // advance the predicted state by one hex beat and queue the base64 beats it causes
  task automatic predict_results(input in_beat_t b);
    logic [3:0] nib;
    logic [7:0] bval;
    bit         flagged;
    out_beat_t  res[MaxResults];
    int         n;
    flagged = 1'b0;
    n = 0;
    if (!decode_hex(b.hex_char, nib)) begin
      flagged = 1'b1;
    end else if (!nib_held) begin
      hi_nib = nib;
      nib_held = 1'b1;
    end else begin
      bval = {hi_nib, nib};
      nib_held = 1'b0;
      hi_nib = 4'h0;
      case (grp_pos)
        GrpSecond: begin
          res[n] = char_beat(sextet_to_ascii({carry_bits[1:0], bval[7:4]}));
          n++;
          carry_bits = bval[3:0];
          grp_pos = GrpThird;
        end
        GrpThird: begin
          res[n] = char_beat(sextet_to_ascii({carry_bits, bval[7:6]}));
          res[n+1] = char_beat(sextet_to_ascii(bval[5:0]));
          n += 2;
          carry_bits = 4'h0;
          grp_pos = GrpFirst;
        end
        default: begin
          res[n] = char_beat(sextet_to_ascii(bval[7:2]));
          n++;
          carry_bits = {2'b00, bval[1:0]};
          grp_pos = GrpSecond;
        end
      endcase
    end
    // odd nibble left at end of stream
    if (b.end_of_stream && nib_held) flagged = 1'b1;
    if (flagged) begin
      res[n] = '{out_char: 8'h00, has_char: 1'b0, bad_input: 1'b1, last_out: 1'b0};
      n++;
    end
    // flush leftover bits and pad the last quartet
    if (b.end_of_stream) begin
      if (grp_pos == GrpSecond) begin
        res[n] = char_beat(sextet_to_ascii({carry_bits[1:0], 4'h0}));
        res[n+1] = char_beat(AsciiPad);
        res[n+2] = char_beat(AsciiPad);
        n += 3;
      end else if (grp_pos == GrpThird) begin
        res[n] = char_beat(sextet_to_ascii({carry_bits, 2'b00}));
        res[n+1] = char_beat(AsciiPad);
        n += 2;
      end
      if (n == 0) begin
        res[n] = '0;
        n++;
      end
      res[n-1].last_out = 1'b1;
      nib_held = 1'b0;
      hi_nib = 4'h0;
      grp_pos = GrpFirst;
      carry_bits = 4'h0;
    end
    for (int i = 0; i < n; i++) b64_expect.push_back(res[i]);
  endtask

  function automatic void push_char(input logic [7:0] ch, input bit eos);
    hex_fifo.push_back('{hex_char: ch, end_of_stream: eos});
    items_queued++;
  endfunction

  // whole stream from a string, end marked on the final character
  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    logic [7:0] v;
    v = 8'($urandom_range(15));
    if (v < 8'd10) return AsciiZero + v;
    return ($urandom_range(1) ? AsciiLowA : AsciiUpA) + v - 8'd10;
  endfunction

  // mostly well-formed streams; some odd length, some with junk inside or at the end
  task automatic queue_random_stream();
    int         shape;
    int         nchars;
    bit         junk_end;
    logic [7:0] junk;
    shape = $urandom_range(99);
    nchars = 2 * ($urandom_range(8) + 1);
    if ($urandom_range(11) == 0) nchars = 2 * $urandom_range(10, 20);
    if (shape >= 75 && shape < 87) nchars--;
    junk_end = (shape >= 95);
    for (int i = 0; i < nchars; i++) begin
      if (shape >= 87 && $urandom_range(5) == 0) begin
        junk = 8'($urandom_range(255));
        push_char(junk, 1'b0);
      end
      push_char(rand_hex_digit(), !junk_end && (i == nchars - 1));
    end
    if (junk_end) begin
      junk = 8'($urandom_range(255));
      push_char(junk, 1'b1);
    end
  endtask

  task automatic queue_random_items(input int count);
    int target;
    target = items_queued + count;
    while (items_queued < target) queue_random_stream();
  endtask

  // block until every queued beat went in and every predicted beat came out
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (hex_fifo.size() != 0 || in_valid_i || b64_expect.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // input beat accepted: predict its results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_results(in_beat_i);
      in_taken = 1'b1;
    end
  end

  // driver: offer the next hex beat once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (hex_fifo.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_beat_i <= hex_fifo.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // monitor: compare each output beat with the oldest prediction
  always @(posedge clk_i) begin : check_out
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (b64_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got %h", $time, out_beat_o);
      end else begin
        want = b64_expect.pop_front();
        check_field("out_char", want.out_char, out_beat_o.out_char);
        check_field("has_char", {7'h00, want.has_char}, {7'h00, out_beat_o.has_char});
        check_field("bad_input", {7'h00, want.bad_input}, {7'h00, out_beat_o.bad_input});
        check_field("last_out", {7'h00, want.last_out}, {7'h00, out_beat_o.last_out});
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("%0t: timeout, %0d beats still expected", $time, b64_expect.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    rst_ni = 1'b0;
    // directed: plain triple, '+' and '/' with one pad, two pads,
    // odd final nibble, junk mid-stream, junk plus odd nibble, junk alone at end
    queue_text("4d616e");
    queue_text("FbFF");
    queue_text("ff");
    queue_text("009");
    push_char("a", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hff, 1'b0);
    push_char("Z", 1'b0);
    push_char("b", 1'b1);
    queue_text("c:");
    queue_text("@");
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait_drained();

    // random with idling, then the sender pauses until all results are in
    queue_random_items(120);
    wait_drained();

    // back to back, no idling on either side
    idle_pct = 0;
    queue_random_items(100);
    wait_drained();

    // idling again, receiver holds off long enough to back up the input
    idle_pct = IdlePct;
    hold_req = 1'b1;
    queue_random_items(130);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/h2b_pkg.sv
src/h2b_front.sv
src/h2b_fifo.sv
src/h2b_back.sv
src/hex_to_base64_encoder_core.sv
tb/tb_hex_to_base64_encoder_core.sv
